/* hw/rtl/three_class_priority_queue_core_defines.svh */
// Assertion macros used by the checker of the priority queue core.
`ifndef THREE_CLASS_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define THREE_CLASS_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// Next-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

/* hw/rtl/tcpq_pkg.sv */
// Types, constants and helper functions of the three-class priority queue.
`default_nettype none
package tcpq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  localparam logic [1:0] FuncEnq   = 2'd0;
  localparam logic [1:0] FuncDeq   = 2'd1;
  localparam logic [1:0] FuncClr   = 2'd2;
  localparam logic [1:0] FuncQuery = 2'd3;

  localparam logic [7:0] TypeD = 8'h44;
  localparam logic [7:0] TypeU = 8'h55;

  localparam logic [1:0] ClassD     = 2'd3;
  localparam logic [1:0] ClassU     = 2'd2;
  localparam logic [1:0] ClassOther = 2'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  type_code;
    logic [15:0] arrival_time;
    logic [15:0] item_tag;
  } in_beat_t;

  typedef struct packed {
    logic        item_valid;
    logic [15:0] out_tag;
    logic [15:0] out_arrival;
    logic [1:0]  out_class;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [15:0] head_tag;
    logic [15:0] tail_tag;
    logic        dropped;
  } out_beat_t;

  // One stored entry of the queue.
  typedef struct packed {
    logic        valid;
    logic [1:0]  cls;
    logic [15:0] arrival;
    logic [15:0] tag;
  } entry_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic        enq;
    logic        deq;
    logic        clr;
    logic [1:0]  cls;
    logic [15:0] arrival;
    logic [15:0] tag;
  } cell_op_t;

  function automatic logic [1:0] class_of(input logic [7:0] code);
    logic [1:0] c;
    c = ClassOther;
    if (code == TypeD) begin
      c = ClassD;
    end else if (code == TypeU) begin
      c = ClassU;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/three_class_priority_queue_core.sv */
// Top level of the three-class priority queue: a chain of sorted cells.
// Usage:
//   The input channel carries one operation per beat: enqueue, dequeue,
//   clear or query. Every accepted beat yields exactly one result beat on
//   the output channel, holding the removed entry (dequeue only), the
//   count, the empty flag, the front and rear tags and the drop flag.
//   The result is registered and appears on the cycle after the input
//   beat is accepted. Throughput is one operation per cycle unless the
//   receiver stalls, set by the cell chain: every cell compares with the
//   new entry in parallel and shifts by one place in the same cycle.
//   The input is ready whenever the output register is empty or its beat
//   is taken in the same cycle; while the receiver stalls, the result is
//   held and no further operation is accepted.
//   Reset empties the queue (all cells invalid, count zero) and drops any
//   pending result beat. There is no clearing pass.
`default_nettype none
module three_class_priority_queue_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tcpq_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tcpq_pkg::out_beat_t      out_data_o
);

  localparam int unsigned Depth = tcpq_pkg::QueueDepth;
  localparam int unsigned CntW  = tcpq_pkg::CntW;

  tcpq_pkg::entry_t   cell_q    [Depth];
  tcpq_pkg::entry_t   cell_next [Depth];
  tcpq_pkg::entry_t   left_ent  [Depth];
  tcpq_pkg::entry_t   right_ent [Depth];
  logic [Depth-1:0]   keep;
  logic [Depth-1:0]   left_keep;
  logic [Depth-1:0]   valid_vec;
  tcpq_pkg::cell_op_t op;

  logic [CntW-1:0]    count_q, count_d;
  logic [15:0]        tail_q, tail_d;
  logic               out_valid_q;
  tcpq_pkg::out_beat_t out_q, out_d;
  logic               fire, full, empty, ins_at_tail;
  logic [CntW+4:0]    count_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(Depth));
  assign empty      = (count_q == '0);

  // Broadcast operation; refused enqueues and empty dequeues change nothing.
  always_comb begin
    op.enq     = fire && (in_data_i.func == tcpq_pkg::FuncEnq) && !full;
    op.deq     = fire && (in_data_i.func == tcpq_pkg::FuncDeq) && !empty;
    op.clr     = fire && (in_data_i.func == tcpq_pkg::FuncClr);
    op.cls     = tcpq_pkg::class_of(in_data_i.type_code);
    op.arrival = in_data_i.arrival_time;
    op.tag     = in_data_i.item_tag;
  end

  // Neighbour wiring of the chain; the ends see an empty neighbour.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_keep[i] = 1'b1;
      assign left_ent[i]  = '0;
    end else begin : g_mid
      assign left_keep[i] = keep[i-1];
      assign left_ent[i]  = cell_q[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_ent[i] = '0;
    end else begin : g_inner
      assign right_ent[i] = cell_q[i+1];
    end
    assign valid_vec[i] = cell_q[i].valid;

    tcpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .left_keep_i  (left_keep[i]),
      .left_entry_i (left_ent[i]),
      .right_entry_i(right_ent[i]),
      .entry_o      (cell_q[i]),
      .entry_next_o (cell_next[i]),
      .keep_o       (keep[i])
    );
  end

  // The new entry lands at the rear when every held entry stays in place.
  assign ins_at_tail = ~|(valid_vec & ~keep);

  // Count and rear tag bookkeeping.
  always_comb begin
    count_d = count_q;
    tail_d  = tail_q;
    if (op.clr) begin
      count_d = '0;
      tail_d  = '0;
    end else if (op.enq) begin
      count_d = count_q + CntW'(1);
      if (ins_at_tail) begin
        tail_d = op.tag;
      end
    end else if (op.deq) begin
      count_d = count_q - CntW'(1);
      if (count_q == CntW'(1)) begin
        tail_d = '0;
      end
    end
  end

  assign count_ext = {5'b0, count_d};

  // Result beat: the removed entry from the front before the operation, the rest from the state after it.
  always_comb begin
    out_d             = '0;
    out_d.item_valid  = op.deq;
    if (op.deq) begin
      out_d.out_tag     = cell_q[0].tag;
      out_d.out_arrival = cell_q[0].arrival;
      out_d.out_class   = cell_q[0].cls;
    end
    out_d.entry_count = count_ext[4:0];
    out_d.is_empty    = (count_d == '0);
    out_d.head_tag    = cell_next[0].valid ? cell_next[0].tag : 16'd0;
    out_d.tail_tag    = tail_d;
    out_d.dropped     = fire && (in_data_i.func == tcpq_pkg::FuncEnq) && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      tail_q  <= tail_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* hw/rtl/tcpq_cell.sv */
// One cell of the sorted shift-register chain.
`default_nettype none
module tcpq_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcpq_pkg::cell_op_t op_i,
  input  wire logic              left_keep_i,
  input  wire tcpq_pkg::entry_t  left_entry_i,
  input  wire tcpq_pkg::entry_t  right_entry_i,
  output tcpq_pkg::entry_t       entry_o,
  output tcpq_pkg::entry_t       entry_next_o,
  output logic                   keep_o
);

  tcpq_pkg::entry_t entry_q, entry_d;
  logic             valid_q;
  logic [1:0]       cls_q;
  logic [15:0]      arrival_q, tag_q;

  // Held entry, gathered from its valid bit and its payload registers.
  assign entry_q = '{valid: valid_q, cls: cls_q, arrival: arrival_q, tag: tag_q};

  // The held entry stays put on an insert when it ranks ahead of the new one.
  assign keep_o = entry_q.valid &&
                  ((entry_q.cls > op_i.cls) ||
                   ((entry_q.cls == op_i.cls) && (entry_q.arrival <= op_i.arrival)));

  // Next entry: keep, take the new entry, shift towards the rear or the front.
  always_comb begin
    entry_d = entry_q;
    if (op_i.clr) begin
      entry_d.valid = 1'b0;
    end else if (op_i.deq) begin
      entry_d = right_entry_i;
    end else if (op_i.enq && !keep_o) begin
      if (left_keep_i) begin
        entry_d.valid   = 1'b1;
        entry_d.cls     = op_i.cls;
        entry_d.arrival = op_i.arrival;
        entry_d.tag     = op_i.tag;
      end else begin
        entry_d = left_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  // Payload needs no reset: it is only read behind the valid bit.
  always_ff @(posedge clk_i) begin
    cls_q     <= entry_d.cls;
    arrival_q <= entry_d.arrival;
    tag_q     <= entry_d.tag;
  end

  assign entry_o      = entry_q;
  assign entry_next_o = entry_d;

endmodule
`default_nettype wire

/* hw/rtl/tcpq_checker.sv */
// Port-level checker of the priority queue core and its bind.
`default_nettype none
`include "three_class_priority_queue_core_defines.svh"
module tcpq_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire tcpq_pkg::in_beat_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire tcpq_pkg::out_beat_t out_data_o
);

  logic in_seen;
  logic empty_tags_zero;
  logic no_item_zero;
  logic item_class_ok;
  logic quiet_result;

  assign in_seen = in_valid_i && in_ready_o && (in_data_i.func == tcpq_pkg::FuncQuery);

  // Properties of the result beat, gathered to keep the checks short.
  assign empty_tags_zero = (out_data_o.entry_count == 5'd0) &&
                           (out_data_o.head_tag == 16'd0) &&
                           (out_data_o.tail_tag == 16'd0);
  assign no_item_zero    = (out_data_o.out_tag == 16'd0) &&
                           (out_data_o.out_arrival == 16'd0) &&
                           (out_data_o.out_class == 2'd0);
  assign item_class_ok   = (out_data_o.out_class != 2'd0) && !out_data_o.dropped;
  assign quiet_result    = !out_data_o.item_valid && !out_data_o.dropped;

  // An empty queue reports a zero count and no front or rear tag.
  `TCPQ_ASSERT_NOW(a_empty_tags, out_valid_o && out_data_o.is_empty, empty_tags_zero)
  // A result without a removed entry carries zero entry fields.
  `TCPQ_ASSERT_NOW(a_no_item_zero, out_valid_o && !out_data_o.item_valid, no_item_zero)
  // A removed entry always has a real class, and a drop never removes.
  `TCPQ_ASSERT_NOW(a_item_class, out_valid_o && out_data_o.item_valid, item_class_ok)
  // A query neither removes nor drops an entry.
  `TCPQ_ASSERT_NEXT(a_query_quiet, in_seen, out_valid_o && quiet_result)
  // A stalled result holds.
  `TCPQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

bind three_class_priority_queue_core tcpq_checker u_tcpq_checker (.*);
`default_nettype wire
